@@ design/psd_pkg.sv @@
package psd_pkg;

   // Coordinate and datapath widths.
   localparam int COORD_WIDTH = 24;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int LEN_W       = PROD_W;
   localparam int DOT_W       = PROD_W + 1;
   localparam int HALF_W      = LEN_W / 2;
   localparam int QUOT_W      = DIFF_W;
   localparam int NUM_W       = LEN_W + QUOT_W;
   localparam int DX_W        = DIFF_W + 2;
   localparam int SQ_W        = 2 * DX_W;
   localparam int DIST_W      = 52;
   localparam int KIND_W      = 2;
   localparam int CFG_W       = 16;

   // Cycles from an accepted beat to its result strobe.
   localparam int PIPE_LATENCY = QUOT_W + 8;

   localparam logic [CFG_W-1:0] MIN_LEN_RESET = 16'd66;

   // Nearest-point codes.
   localparam logic [KIND_W-1:0] KIND_START    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INTERIOR = 2'd2;

   // Per-item data that rides alongside the divider.
   typedef struct packed {
      logic signed [DIFF_W-1:0] ax;
      logic signed [DIFF_W-1:0] ay;
      logic signed [DIFF_W-1:0] bx;
      logic signed [DIFF_W-1:0] by;
      logic [KIND_W-1:0]        kind;
      logic                     neg_x;
      logic                     neg_y;
   } side_type;

endpackage

@@ design/point_segment_distance_sq.sv @@
// An accepted beat passes stages 1 to 5, the divider and stages 6 to 8 to its rsp_valid strobe.
// Throughput: one beat per cycle; busy is never raised.
// The depth is set by the projection divider, 25 stages with one quotient
// bit each, for each axis.
// Reset clears all valid bits and sets the threshold register min_len_ff to 66.
// The receiver cannot stall; each result is shown for one cycle only.
module point_segment_distance_sq (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0]  req_point_x,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0]  req_point_y,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0]  req_start_x,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0]  req_start_y,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0]  req_end_x,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0]  req_end_y,
   input  logic                                    csr_wr_en,
   input  logic [psd_pkg::CFG_W-1:0]               csr_wr_data,
   output logic                                    rsp_valid,
   output logic [psd_pkg::DIST_W-1:0]              rsp_distance_sq,
   output logic [psd_pkg::KIND_W-1:0]              rsp_closest_kind
);

   localparam int CW = psd_pkg::COORD_WIDTH;
   localparam int DW = psd_pkg::DIFF_W;
   localparam int PW = psd_pkg::PROD_W;
   localparam int LW = psd_pkg::LEN_W;
   localparam int HW = psd_pkg::HALF_W;
   localparam int QW = psd_pkg::QUOT_W;
   localparam int XW = psd_pkg::DX_W;
   localparam int SW = psd_pkg::SQ_W;

   logic [psd_pkg::CFG_W-1:0] min_len_ff;

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= psd_pkg::MIN_LEN_RESET;
      end else if (csr_wr_en) begin
         min_len_ff <= csr_wr_data;
      end
   end

   assign busy = 1'b0;

   // Stage 1: coordinate differences.
   logic                 s1_valid_ff;
   psd_pkg::side_type    s1_side_ff;
   logic signed [DW-1:0] s1_cx_ff, s1_cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_side_ff.ax    <= {req_point_x[CW-1], req_point_x} - {req_start_x[CW-1], req_start_x};
      s1_side_ff.ay    <= {req_point_y[CW-1], req_point_y} - {req_start_y[CW-1], req_start_y};
      s1_side_ff.bx    <= {req_point_x[CW-1], req_point_x} - {req_end_x[CW-1], req_end_x};
      s1_side_ff.by    <= {req_point_y[CW-1], req_point_y} - {req_end_y[CW-1], req_end_y};
      s1_side_ff.kind  <= psd_pkg::KIND_START;
      s1_side_ff.neg_x <= 1'b0;
      s1_side_ff.neg_y <= 1'b0;
      s1_cx_ff <= {req_end_x[CW-1], req_end_x} - {req_start_x[CW-1], req_start_x};
      s1_cy_ff <= {req_end_y[CW-1], req_end_y} - {req_start_y[CW-1], req_start_y};
   end

   // Stage 2: the four products and the delta magnitudes.
   logic                 s2_valid_ff;
   psd_pkg::side_type    s2_side_ff;
   logic signed [PW-1:0] s2_pxc_ff, s2_pyc_ff, s2_lxx_ff, s2_lyy_ff;
   logic [DW-1:0]        s2_abs_x_ff, s2_abs_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_side_ff.ax    <= s1_side_ff.ax;
      s2_side_ff.ay    <= s1_side_ff.ay;
      s2_side_ff.bx    <= s1_side_ff.bx;
      s2_side_ff.by    <= s1_side_ff.by;
      s2_side_ff.kind  <= s1_side_ff.kind;
      s2_side_ff.neg_x <= s1_cx_ff[DW-1];
      s2_side_ff.neg_y <= s1_cy_ff[DW-1];
      s2_pxc_ff   <= s1_side_ff.ax * s1_cx_ff;
      s2_pyc_ff   <= s1_side_ff.ay * s1_cy_ff;
      s2_lxx_ff   <= s1_cx_ff * s1_cx_ff;
      s2_lyy_ff   <= s1_cy_ff * s1_cy_ff;
      s2_abs_x_ff <= s1_cx_ff[DW-1] ? DW'(-s1_cx_ff) : DW'(s1_cx_ff);
      s2_abs_y_ff <= s1_cy_ff[DW-1] ? DW'(-s1_cy_ff) : DW'(s1_cy_ff);
   end

   // Stage 3: dot product, squared length and the nearest-point decision.
   logic signed [psd_pkg::DOT_W-1:0] dot_in;
   logic [LW-1:0]                    len_in;
   logic [psd_pkg::KIND_W-1:0]       kind_in;

   assign dot_in = {s2_pxc_ff[PW-1], s2_pxc_ff} + {s2_pyc_ff[PW-1], s2_pyc_ff};
   assign len_in = s2_lxx_ff + s2_lyy_ff;

   always_comb begin
      if (len_in <= LW'(min_len_ff) || dot_in[psd_pkg::DOT_W-1]) begin
         kind_in = psd_pkg::KIND_START;
      end else if (dot_in > $signed({1'b0, len_in})) begin
         kind_in = psd_pkg::KIND_END;
      end else begin
         kind_in = psd_pkg::KIND_INTERIOR;
      end
   end

   logic              s3_valid_ff;
   psd_pkg::side_type s3_side_ff;
   logic [LW-1:0]     s3_dot_ff, s3_len_ff;
   logic [DW-1:0]     s3_abs_x_ff, s3_abs_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_side_ff.ax    <= s2_side_ff.ax;
      s3_side_ff.ay    <= s2_side_ff.ay;
      s3_side_ff.bx    <= s2_side_ff.bx;
      s3_side_ff.by    <= s2_side_ff.by;
      s3_side_ff.kind  <= kind_in;
      s3_side_ff.neg_x <= s2_side_ff.neg_x;
      s3_side_ff.neg_y <= s2_side_ff.neg_y;
      s3_dot_ff        <= dot_in[LW-1:0];
      s3_len_ff        <= len_in;
      s3_abs_x_ff      <= s2_abs_x_ff;
      s3_abs_y_ff      <= s2_abs_y_ff;
   end

   // Stage 4: partial products of dot times each delta magnitude.
   logic              s4_valid_ff;
   psd_pkg::side_type s4_side_ff;
   logic [LW-1:0]     s4_len_ff;
   logic [2*HW-1:0]   s4_xlo_ff, s4_xhi_ff, s4_ylo_ff, s4_yhi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_side_ff <= s3_side_ff;
      s4_len_ff  <= s3_len_ff;
      s4_xlo_ff  <= s3_dot_ff[HW-1:0] * s3_abs_x_ff;
      s4_xhi_ff  <= s3_dot_ff[LW-1:HW] * s3_abs_x_ff;
      s4_ylo_ff  <= s3_dot_ff[HW-1:0] * s3_abs_y_ff;
      s4_yhi_ff  <= s3_dot_ff[LW-1:HW] * s3_abs_y_ff;
   end

   // Stage 5: assemble the full numerators.
   logic                          s5_valid_ff;
   psd_pkg::side_type             s5_side_ff;
   logic [LW-1:0]                 s5_len_ff;
   logic [psd_pkg::NUM_W-1:0]     s5_num_x_ff, s5_num_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_side_ff  <= s4_side_ff;
      s5_len_ff   <= s4_len_ff;
      s5_num_x_ff <= {s4_xhi_ff, {HW{1'b0}}} + {{HW{1'b0}}, s4_xlo_ff};
      s5_num_y_ff <= {s4_yhi_ff, {HW{1'b0}}} + {{HW{1'b0}}, s4_ylo_ff};
   end

   // Divider per axis, with the side data delayed to match.
   logic [QW-1:0] quot_x, quot_y;

   psd_div u_div_x (
      .clock    (clock),
      .num_in   (s5_num_x_ff),
      .den_in   (s5_len_ff),
      .quot_out (quot_x)
   );

   psd_div u_div_y (
      .clock    (clock),
      .num_in   (s5_num_y_ff),
      .den_in   (s5_len_ff),
      .quot_out (quot_y)
   );

   psd_pkg::side_type side_ff [QW];
   logic [QW-1:0]     dv_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff <= '0;
      end else begin
         dv_valid_ff <= {dv_valid_ff[QW-2:0], s5_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= s5_side_ff;
      for (int k = 1; k < QW; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // Stage 6: offset to the nearest point on each axis.
   psd_pkg::side_type    dv_side;
   logic signed [XW-1:0] off_x, off_y, dx_in, dy_in;

   assign dv_side = side_ff[QW-1];
   assign off_x = dv_side.neg_x ? -$signed({2'b00, quot_x}) : $signed({2'b00, quot_x});
   assign off_y = dv_side.neg_y ? -$signed({2'b00, quot_y}) : $signed({2'b00, quot_y});

   always_comb begin
      case (dv_side.kind)
         psd_pkg::KIND_END: begin
            dx_in = XW'(dv_side.bx);
            dy_in = XW'(dv_side.by);
         end
         psd_pkg::KIND_INTERIOR: begin
            dx_in = XW'(dv_side.ax) - off_x;
            dy_in = XW'(dv_side.ay) - off_y;
         end
         default: begin
            dx_in = XW'(dv_side.ax);
            dy_in = XW'(dv_side.ay);
         end
      endcase
   end

   logic                       s6_valid_ff;
   logic [psd_pkg::KIND_W-1:0] s6_kind_ff;
   logic signed [XW-1:0]       s6_dx_ff, s6_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= dv_valid_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      s6_kind_ff <= dv_side.kind;
      s6_dx_ff   <= dx_in;
      s6_dy_ff   <= dy_in;
   end

   // Stage 7: squares, computed at the full product width.
   logic                       s7_valid_ff;
   logic [psd_pkg::KIND_W-1:0] s7_kind_ff;
   logic [SW-1:0]              s7_sq_x_ff, s7_sq_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s7_kind_ff <= s6_kind_ff;
      s7_sq_x_ff <= s6_dx_ff * s6_dx_ff;
      s7_sq_y_ff <= s6_dy_ff * s6_dy_ff;
   end

   // Stage 8: sum with saturation to the result width.
   logic [SW:0] sum_in;

   assign sum_in = {1'b0, s7_sq_x_ff} + {1'b0, s7_sq_y_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_closest_kind <= s7_kind_ff;
      if (sum_in[SW:psd_pkg::DIST_W] != '0) begin
         rsp_distance_sq <= '1;
      end else begin
         rsp_distance_sq <= sum_in[psd_pkg::DIST_W-1:0];
      end
   end

endmodule

@@ design/psd_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module psd_div (
   input  logic                            clock,
   input  logic [psd_pkg::NUM_W-1:0]       num_in,
   input  logic [psd_pkg::LEN_W-1:0]       den_in,
   output logic [psd_pkg::QUOT_W-1:0]      quot_out
);

   logic [psd_pkg::LEN_W-1:0]  rem_ff     [psd_pkg::QUOT_W];
   logic [psd_pkg::QUOT_W-1:0] low_ff     [psd_pkg::QUOT_W];
   logic [psd_pkg::QUOT_W-1:0] quot_ff    [psd_pkg::QUOT_W];
   logic [psd_pkg::LEN_W-1:0]  divisor_ff [psd_pkg::QUOT_W];
   logic [psd_pkg::LEN_W-1:0]  rem_in     [psd_pkg::QUOT_W];
   logic [psd_pkg::QUOT_W-1:0] low_in     [psd_pkg::QUOT_W];
   logic [psd_pkg::QUOT_W-1:0] quot_in    [psd_pkg::QUOT_W];
   logic [psd_pkg::LEN_W-1:0]  divisor_in [psd_pkg::QUOT_W];

   // Each stage shifts in the next numerator bit and subtracts when it fits.
   // The first stage starts from the upper numerator bits.
   always_comb begin
      logic [psd_pkg::LEN_W-1:0]  rem_prev;
      logic [psd_pkg::LEN_W-1:0]  den_prev;
      logic [psd_pkg::QUOT_W-1:0] low_prev;
      logic [psd_pkg::QUOT_W-1:0] quot_prev;
      logic [psd_pkg::LEN_W:0]    trial;
      logic [psd_pkg::LEN_W:0]    diff;
      logic                       take;
      for (int j = 0; j < psd_pkg::QUOT_W; j++) begin
         if (j == 0) begin
            rem_prev  = num_in[psd_pkg::NUM_W-1:psd_pkg::QUOT_W];
            low_prev  = num_in[psd_pkg::QUOT_W-1:0];
            quot_prev = '0;
            den_prev  = den_in;
         end else begin
            rem_prev  = rem_ff[j-1];
            low_prev  = low_ff[j-1];
            quot_prev = quot_ff[j-1];
            den_prev  = divisor_ff[j-1];
         end
         trial = {rem_prev, low_prev[psd_pkg::QUOT_W-1]};
         take  = trial >= {1'b0, den_prev};
         diff  = trial - {1'b0, den_prev};
         rem_in[j]     = take ? diff[psd_pkg::LEN_W-1:0] : trial[psd_pkg::LEN_W-1:0];
         low_in[j]     = {low_prev[psd_pkg::QUOT_W-2:0], 1'b0};
         quot_in[j]    = {quot_prev[psd_pkg::QUOT_W-2:0], take};
         divisor_in[j] = den_prev;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < psd_pkg::QUOT_W; j++) begin
         rem_ff[j]     <= rem_in[j];
         low_ff[j]     <= low_in[j];
         quot_ff[j]    <= quot_in[j];
         divisor_ff[j] <= divisor_in[j];
      end
   end

   assign quot_out = quot_ff[psd_pkg::QUOT_W-1];

endmodule

@@ design/psd_checker.sv @@
// Port-level checks on the distance pipeline.
module psd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [psd_pkg::KIND_W-1:0]       rsp_closest_kind
);

   // Every accepted beat produces a result after the fixed latency.
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(psd_pkg::PIPE_LATENCY) rsp_valid)
      else $error("accepted beat produced no result");

   // No result appears without a beat accepted the matching time earlier.
   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, psd_pkg::PIPE_LATENCY))
      else $error("result without a matching accepted beat");

   // The kind code is one of the three defined values.
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_closest_kind == psd_pkg::KIND_START ||
                     rsp_closest_kind == psd_pkg::KIND_END ||
                     rsp_closest_kind == psd_pkg::KIND_INTERIOR))
      else $error("illegal closest kind");

endmodule

bind point_segment_distance_sq psd_checker u_psd_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_closest_kind (rsp_closest_kind)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

   typedef logic signed [psd_pkg::COORD_WIDTH-1:0] coord_type;

   // One entry of the stimulus list: either a query beat or a register write.
   typedef struct {
      bit                         is_write;
      logic [psd_pkg::CFG_W-1:0]  wr_value;
      bit                         burst;
      coord_type                  px, py, sx, sy, ex, ey;
   } query_type;

   typedef struct {
      logic [psd_pkg::DIST_W-1:0] distance_sq;
      logic [psd_pkg::KIND_W-1:0] kind;
   } result_type;

   localparam int WATCHDOG_LIMIT = 4000;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   coord_type                   req_point_x, req_point_y, req_start_x, req_start_y;
   coord_type                   req_end_x, req_end_y;
   logic                        csr_wr_en;
   logic [psd_pkg::CFG_W-1:0]   csr_wr_data;
   logic                        rsp_valid;
   logic [psd_pkg::DIST_W-1:0]  rsp_distance_sq;
   logic [psd_pkg::KIND_W-1:0]  rsp_closest_kind;

   query_type                   pending_queries[$];
   result_type                  expected_distances[$];
   query_type                   driven_query;
   logic [psd_pkg::CFG_W-1:0]   model_min_len;
   int                          gap_count;
   int                          settle_count;
   bit                          burst_mode;
   int                          idle_cycles;
   int                          error_count = 0;

   point_segment_distance_sq i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_distance_sq  (rsp_distance_sq),
      .rsp_closest_kind (rsp_closest_kind)
   );

   // Clock with a 10 ns period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Projection offset on one axis, truncated toward zero.
   function automatic longint axis_offset(longint dot, longint delta, longint len_sq);
      logic [127:0] num;
      logic [127:0] quot;
      longint       mag;
      mag  = (delta < 0) ? -delta : delta;
      num  = 128'(dot) * 128'(mag);
      quot = num / 128'(len_sq);
      return (delta < 0) ? -longint'(quot) : longint'(quot);
   endfunction

   // Nearest point on the segment and its squared distance.
   function automatic result_type nearest_distance(query_type q,
                                                   logic [psd_pkg::CFG_W-1:0] min_len);
      result_type r;
      longint ax, ay, cx, cy, dot, len_sq, dx, dy;
      logic [127:0] sum;
      ax     = longint'(q.px) - longint'(q.sx);
      ay     = longint'(q.py) - longint'(q.sy);
      cx     = longint'(q.ex) - longint'(q.sx);
      cy     = longint'(q.ey) - longint'(q.sy);
      dot    = ax * cx + ay * cy;
      len_sq = cx * cx + cy * cy;
      if (len_sq <= longint'(min_len) || dot < 0) begin
         dx     = ax;
         dy     = ay;
         r.kind = psd_pkg::KIND_START;
      end else if (dot > len_sq) begin
         dx     = longint'(q.px) - longint'(q.ex);
         dy     = longint'(q.py) - longint'(q.ey);
         r.kind = psd_pkg::KIND_END;
      end else begin
         dx     = ax - axis_offset(dot, cx, len_sq);
         dy     = ay - axis_offset(dot, cy, len_sq);
         r.kind = psd_pkg::KIND_INTERIOR;
      end
      sum = 128'(dx * dx) + 128'(dy * dy);
      if (sum > {76'd0, {psd_pkg::DIST_W{1'b1}}}) begin
         r.distance_sq = {psd_pkg::DIST_W{1'b1}};
      end else begin
         r.distance_sq = sum[psd_pkg::DIST_W-1:0];
      end
      return r;
   endfunction

   function automatic coord_type random_coord(int mode);
      case (mode)
         0: begin
            return coord_type'($urandom);
         end
         1: begin
            return coord_type'($signed($urandom_range(0, 8000)) - 4000);
         end
         default: begin
            return $urandom_range(0, 1) ? {1'b0, {(psd_pkg::COORD_WIDTH-1){1'b1}}}
                                        : {1'b1, {(psd_pkg::COORD_WIDTH-1){1'b0}}};
         end
      endcase
   endfunction

   task automatic add_query(int px, int py, int sx, int sy, int ex, int ey);
      query_type q;
      q          = '{default: '0};
      q.px       = coord_type'(px);
      q.py       = coord_type'(py);
      q.sx       = coord_type'(sx);
      q.sy       = coord_type'(sy);
      q.ex       = coord_type'(ex);
      q.ey       = coord_type'(ey);
      pending_queries.push_back(q);
   endtask

   // A register write also makes the sender wait for every result in flight.
   task automatic add_write(logic [psd_pkg::CFG_W-1:0] value);
      query_type q;
      q          = '{default: '0};
      q.is_write = 1'b1;
      q.wr_value = value;
      q.burst    = ($urandom_range(0, 3) == 0);
      pending_queries.push_back(q);
   endtask

   task automatic add_random_queries(int count);
      query_type q;
      int        mode;
      int        shape;
      for (int i = 0; i < count; i++) begin
         q     = '{default: '0};
         mode  = ($urandom_range(0, 2) == 0) ? 0 : 1;
         shape = $urandom_range(0, 9);
         q.sx  = random_coord(mode);
         q.sy  = random_coord(mode);
         q.ex  = random_coord(mode);
         q.ey  = random_coord(mode);
         q.px  = random_coord(mode);
         q.py  = random_coord(mode);
         if (shape == 0) begin
            // Very short segment, near the threshold.
            q.ex = q.sx + coord_type'($signed($urandom_range(0, 20)) - 10);
            q.ey = q.sy + coord_type'($signed($urandom_range(0, 20)) - 10);
         end else if (shape == 1) begin
            q.px = random_coord(2);
            q.ex = random_coord(2);
            q.sy = random_coord(2);
         end else if (shape < 6 && mode == 1) begin
            // Point between the ends, so the projection lands inside.
            q.px = (q.sx + q.ex) / 2 + coord_type'($signed($urandom_range(0, 200)) - 100);
            q.py = (q.sy + q.ey) / 2 + coord_type'($signed($urandom_range(0, 200)) - 100);
         end
         pending_queries.push_back(q);
      end
   endtask

   // Stimulus list: directed cases, then random phases under several thresholds.
   initial begin
      // Default threshold: short segment, just-long segment, ends and bounds.
      add_query(100, 100, 0, 0, 8, 1);
      add_query(100, 100, 0, 0, 8, 2);
      add_query(-50, 0, 0, 0, 1000, 0);
      add_query(2000, 30, 0, 0, 1000, 0);
      add_query(0, 500, 0, 0, 1000, 0);
      add_query(1000, 700, 0, 0, 1000, 0);
      add_query(300, -77, 0, 0, 1000, 0);
      add_query(123, 456, -900, 300, 700, -250);
      add_query(8388607, 8388607, -8388608, -8388608, 8388607, 8388607);
      add_query(-8388608, 8388607, 8388607, -8388608, -8388608, -8388608);
      add_query(8388607, -8388608, -8388608, 8388607, 8388607, -8388608);
      add_query(0, 0, -8388608, -8388608, 8388607, 8388607);
      add_query(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607);
      add_query(5, 5, 0, 0, 0, 0);
      add_write(16'd65);
      add_query(100, 100, 0, 0, 8, 1);
      add_query(100, 100, 0, 0, 8, 2);
      add_write(16'd0);
      add_query(7, 9, 3, 3, 3, 3);
      add_query(7, 9, 3, 3, 4, 3);
      add_query(7, 9, 3, 3, 3, 2);
      add_write(16'hFFFF);
      add_query(1000, 1000, 0, 0, 255, 0);
      add_query(1000, 1000, 0, 0, 256, 0);
      add_random_queries(150);
      add_write(16'd0);
      add_random_queries(150);
      add_write(16'd66);
      add_random_queries(150);
      add_write(16'd1000);
      add_random_queries(150);
      add_write(16'($urandom));
      add_random_queries(150);
      add_write(16'hFFFF);
      add_random_queries(150);
   end

   // Driver: one beat per entry; after each query a random gap is drawn, or none in burst mode.
   always @(posedge clock) begin
      logic next_start;
      logic next_wr_en;
      if (reset) begin
         start         <= 1'b0;
         csr_wr_en     <= 1'b0;
         csr_wr_data   <= '0;
         req_point_x   <= '0;
         req_point_y   <= '0;
         req_start_x   <= '0;
         req_start_y   <= '0;
         req_end_x     <= '0;
         req_end_y     <= '0;
         model_min_len <= psd_pkg::MIN_LEN_RESET;
         gap_count     <= 0;
         settle_count  <= 0;
         burst_mode    <= 1'b0;
      end else begin
         next_start = start && busy;
         next_wr_en = 1'b0;
         if (start && !busy) begin
            expected_distances.push_back(nearest_distance(driven_query, model_min_len));
         end
         if (expected_distances.size() == 0 && !(start && !busy)) begin
            settle_count <= settle_count + 1;
         end else begin
            settle_count <= 0;
         end
         if (!next_start) begin
            if (gap_count > 0) begin
               gap_count <= gap_count - 1;
            end else if (pending_queries.size() > 0) begin
               if (pending_queries[0].is_write) begin
                  if (!start && expected_distances.size() == 0 &&
                      settle_count > psd_pkg::PIPE_LATENCY + 2) begin
                     next_wr_en    = 1'b1;
                     csr_wr_data   <= pending_queries[0].wr_value;
                     model_min_len <= pending_queries[0].wr_value;
                     burst_mode    <= pending_queries[0].burst;
                     void'(pending_queries.pop_front());
                  end
               end else begin
                  driven_query = pending_queries.pop_front();
                  req_point_x <= driven_query.px;
                  req_point_y <= driven_query.py;
                  req_start_x <= driven_query.sx;
                  req_start_y <= driven_query.sy;
                  req_end_x   <= driven_query.ex;
                  req_end_y   <= driven_query.ey;
                  next_start  = 1'b1;
                  gap_count   <= burst_mode ? 0 : $urandom_range(0, 8);
               end
            end
         end
         start     <= next_start;
         csr_wr_en <= next_wr_en;
      end
   end

   // Monitor: each result beat is checked against the oldest expectation.
   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_distances.size() == 0) begin
            $error("unexpected result beat: distance_sq %0d closest_kind %0d",
                   rsp_distance_sq, rsp_closest_kind);
            error_count++;
         end else begin
            exp_r = expected_distances.pop_front();
            if (rsp_distance_sq !== exp_r.distance_sq) begin
               $error("distance_sq: expected %0d, actual %0d",
                      exp_r.distance_sq, rsp_distance_sq);
               error_count++;
            end
            if (rsp_closest_kind !== exp_r.kind) begin
               $error("closest_kind: expected %0d, actual %0d", exp_r.kind, rsp_closest_kind);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which no beat moves on any port.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Reset, then wait for the stimulus and all results to drain.
   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_queries.size() > 0 || start || expected_distances.size() > 0) begin
         @(posedge clock);
      end
      repeat (psd_pkg::PIPE_LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
